// ----- rtl/next_permutation_engine_top_defines.svh -----
// Assertion macros for the next-permutation engine top level.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef NEXT_PERMUTATION_ENGINE_TOP_DEFINES_SVH
`define NEXT_PERMUTATION_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define NEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define NEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NEP_ASSERT_NOW(lbl, ante, cons, msg)
`define NEP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/nep_pkg.sv -----
// Shared types, constants and the word compare for the next-permutation engine.
// No dependencies; every other RTL file but the defines header refers to this package.
`default_nettype none

package nep_pkg;

	localparam int MAX_ELEMENTS_DEF = 8;
	localparam int RESULT_LIMIT     = 8;
	localparam int WORD_W           = 32;
	localparam int POS_W            = 3;
	localparam int CNT_W            = 4;
	localparam int PADDR_W          = 3;
	localparam int PDATA_W          = 32;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	// register index is paddr[2]
	localparam logic CFG_IDX_ELEMENT_COUNT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PIV_RD,
		ST_PIV_EV,
		ST_SUC_RD,
		ST_SUC_EV,
		ST_SWP_WR,
		ST_REV_RD,
		ST_REV_EV,
		ST_REV_WR,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WT
	} seq_state_t;

	typedef struct packed {
		logic              we;
		logic [POS_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [POS_W-1:0]  raddr_a;
		logic [POS_W-1:0]  raddr_b;
	} store_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] rd_a;
		logic [WORD_W-1:0] rd_b;
	} store_rsp_t;

	// signed less-than on stored words
	function automatic logic word_less(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/nep_in_if.sv -----
// Input channel of the next-permutation engine: valid/ready plus load/advance payload.
// Depends on nep_pkg for field widths.
`default_nettype none

interface nep_in_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [nep_pkg::POS_W-1:0]        position;
	logic signed [nep_pkg::WORD_W-1:0] value;

	modport source(output valid, output kind, output position, output value, input ready);
	modport sink(input valid, input kind, input position, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/nep_out_if.sv -----
// Output channel of the next-permutation engine: valid/ready plus one emitted word.
// Depends on nep_pkg for field widths.
`default_nettype none

interface nep_out_if;
	logic                             valid;
	logic                             ready;
	logic [nep_pkg::POS_W-1:0]        out_position;
	logic signed [nep_pkg::WORD_W-1:0] out_value;
	logic                             advanced;
	logic                             last_of_run;

	modport source(output valid, output out_position, output out_value, output advanced,
		output last_of_run, input ready);
	modport sink(input valid, input out_position, input out_value, input advanced,
		input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/next_permutation_engine_top.sv -----
// Next-permutation engine top level: APB count register, sequencer and word store.
// Depends on nep_pkg, nep_in_if, nep_out_if, nep_store, nep_seq and the defines header.
//
// Usage:
//   in_ch carries load transactions (kind 0: write value at position) and advance
//   transactions (kind 1). A load completes in the cycle it is accepted and returns
//   nothing. An advance rearranges the first n = min(element_count, depth) words into
//   the next lexicographic order and then returns n transactions on out_ch, one per
//   word in position order, advanced set if a next order existed, last_of_run on the
//   final one. n = 0 returns nothing.
//   in_ch.ready is high only while no advance is in progress.
//   Advance time grows with the steps of the pivot scan, the steps of the successor scan,
//   the swaps in the tail and the n emitted words, plus any time the receiver stalls.
//   It is set by the single comparator and the single store write port, one compare or
//   write per cycle.
//   A stalled receiver simply holds the current word in the output register.
//   Reset clears the control state and element_count; the store contents are
//   undefined until loaded. Write element_count over APB only while idle.
`default_nettype none

`include "next_permutation_engine_top_defines.svh"

module next_permutation_engine_top #(
	parameter int MAX_ELEMENTS = nep_pkg::MAX_ELEMENTS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	nep_in_if.sink                      in_ch,
	nep_out_if.source                   out_ch,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [nep_pkg::PADDR_W-1:0]  paddr,
	input  wire [nep_pkg::PDATA_W-1:0]  pwdata,
	output logic [nep_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	logic [nep_pkg::CNT_W-1:0] element_count_q;
	logic                      cfg_wr;
	nep_pkg::store_req_t       store_req;
	nep_pkg::store_rsp_t       store_rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_wr && paddr[2] == nep_pkg::CFG_IDX_ELEMENT_COUNT) begin
			element_count_q <= pwdata[nep_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == nep_pkg::CFG_IDX_ELEMENT_COUNT) begin
			prdata = nep_pkg::PDATA_W'(element_count_q);
		end
	end

	nep_seq #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.element_count(element_count_q),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.req          (store_req),
		.rsp          (store_rsp)
	);

	nep_store #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_store (
		.clk(clk),
		.req(store_req),
		.rsp(store_rsp)
	);

	`NEP_ASSERT_NOW(a_busy_excl, in_ch.ready, !out_ch.valid, "input ready while emitting")
	`NEP_ASSERT_NEXT(a_last_frees, out_ch.valid && out_ch.ready && out_ch.last_of_run, in_ch.ready, "engine not idle after last word")
	`NEP_ASSERT_NEXT(a_empty_run, in_ch.valid && in_ch.ready && in_ch.kind == nep_pkg::KIND_ADVANCE && element_count_q == nep_pkg::CNT_W'(0), in_ch.ready, "empty advance left engine busy")
	`NEP_ASSERT_NOW(a_pos_range, out_ch.valid, nep_pkg::CNT_W'(out_ch.out_position) < element_count_q, "emitted position beyond count")

endmodule

`default_nettype wire

// ----- rtl/nep_store.sv -----
// Word store: one write port, two registered read ports.
// Depends on nep_pkg (request/response structs).
`default_nettype none

module nep_store #(
	parameter int MAX_ELEMENTS = nep_pkg::MAX_ELEMENTS_DEF
) (
	input  wire                 clk,
	input  nep_pkg::store_req_t req,
	output nep_pkg::store_rsp_t rsp
);

	localparam int DEPTH = (MAX_ELEMENTS > nep_pkg::RESULT_LIMIT) ?
		nep_pkg::RESULT_LIMIT : MAX_ELEMENTS;
	localparam int AW = $clog2(DEPTH);

	logic [nep_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		rsp.rd_a <= mem[req.raddr_a[AW-1:0]];
		rsp.rd_b <= mem[req.raddr_b[AW-1:0]];
	end

endmodule

`default_nettype wire

// ----- rtl/nep_seq.sv -----
// Sequencer: pivot scan, successor scan, swap, tail reversal and emission,
// all through one signed comparator and the two-read store. Depends on nep_pkg.
`default_nettype none

module nep_seq #(
	parameter int MAX_ELEMENTS = nep_pkg::MAX_ELEMENTS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire [nep_pkg::CNT_W-1:0]   element_count,
	nep_in_if.sink                     in_ch,
	nep_out_if.source                  out_ch,
	output nep_pkg::store_req_t        req,
	input  nep_pkg::store_rsp_t        rsp
);

	localparam int DEPTH = (MAX_ELEMENTS > nep_pkg::RESULT_LIMIT) ?
		nep_pkg::RESULT_LIMIT : MAX_ELEMENTS;

	nep_pkg::seq_state_t state_q, state_d;

	logic [nep_pkg::CNT_W-1:0]  n_q;
	logic [nep_pkg::POS_W-1:0]  i_q, p_q, s_q, lo_q, hi_q, k_q;
	logic [nep_pkg::WORD_W-1:0] hold_q;
	logic                       moved_q;
	logic [nep_pkg::POS_W-1:0]  out_pos_q;
	logic [nep_pkg::WORD_W-1:0] out_val_q;
	logic                       out_adv_q, out_last_q;

	logic                       accept;
	logic                       lt;
	logic                       load_in_range;
	logic [nep_pkg::CNT_W-1:0]  n_eff;
	logic [nep_pkg::POS_W-1:0]  n_last;
	logic [nep_pkg::POS_W-1:0]  p_next;
	logic                       suc_found;
	logic                       k_last;

	assign accept        = in_ch.valid && in_ch.ready;
	assign lt            = nep_pkg::word_less(rsp.rd_a, rsp.rd_b);
	assign load_in_range = 32'(in_ch.position) < 32'(MAX_ELEMENTS);
	assign n_eff         = (element_count > nep_pkg::CNT_W'(DEPTH)) ?
		nep_pkg::CNT_W'(DEPTH) : element_count;
	assign n_last        = nep_pkg::POS_W'(n_q - nep_pkg::CNT_W'(1));
	assign p_next        = p_q + nep_pkg::POS_W'(1);
	// the word right after the pivot is always larger
	assign suc_found     = lt || (s_q == p_next);
	assign k_last        = (nep_pkg::CNT_W'(k_q) + nep_pkg::CNT_W'(1)) == n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nep_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nep_pkg::ST_IDLE: begin
				if (accept && in_ch.kind == nep_pkg::KIND_ADVANCE) begin
					if (n_eff == nep_pkg::CNT_W'(0)) begin
						state_d = nep_pkg::ST_IDLE;
					end else if (n_eff == nep_pkg::CNT_W'(1)) begin
						state_d = nep_pkg::ST_EMIT_RD;
					end else begin
						state_d = nep_pkg::ST_PIV_RD;
					end
				end
			end
			nep_pkg::ST_PIV_RD: state_d = nep_pkg::ST_PIV_EV;
			nep_pkg::ST_PIV_EV: begin
				if (lt) begin
					state_d = nep_pkg::ST_SUC_RD;
				end else if (i_q == nep_pkg::POS_W'(1)) begin
					state_d = nep_pkg::ST_EMIT_RD;
				end else begin
					state_d = nep_pkg::ST_PIV_RD;
				end
			end
			nep_pkg::ST_SUC_RD: state_d = nep_pkg::ST_SUC_EV;
			nep_pkg::ST_SUC_EV: begin
				state_d = suc_found ? nep_pkg::ST_SWP_WR : nep_pkg::ST_SUC_RD;
			end
			nep_pkg::ST_SWP_WR: begin
				state_d = (p_next < n_last) ? nep_pkg::ST_REV_RD : nep_pkg::ST_EMIT_RD;
			end
			nep_pkg::ST_REV_RD: state_d = nep_pkg::ST_REV_EV;
			nep_pkg::ST_REV_EV: state_d = nep_pkg::ST_REV_WR;
			nep_pkg::ST_REV_WR: begin
				state_d = ((lo_q + nep_pkg::POS_W'(1)) < (hi_q - nep_pkg::POS_W'(1))) ?
					nep_pkg::ST_REV_RD : nep_pkg::ST_EMIT_RD;
			end
			nep_pkg::ST_EMIT_RD: state_d = nep_pkg::ST_EMIT_LD;
			nep_pkg::ST_EMIT_LD: state_d = nep_pkg::ST_EMIT_WT;
			nep_pkg::ST_EMIT_WT: begin
				if (out_ch.ready) begin
					state_d = k_last ? nep_pkg::ST_IDLE : nep_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = nep_pkg::ST_IDLE;
		endcase
	end

	// outputs and store requests
	always_comb begin
		in_ch.ready   = 1'b0;
		out_ch.valid  = 1'b0;
		req.we        = 1'b0;
		req.waddr     = in_ch.position;
		req.wdata     = in_ch.value;
		req.raddr_a   = k_q;
		req.raddr_b   = k_q;
		unique case (state_q)
			nep_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				req.we      = accept && in_ch.kind == nep_pkg::KIND_LOAD && load_in_range;
			end
			nep_pkg::ST_PIV_RD: begin
				req.raddr_a = i_q - nep_pkg::POS_W'(1);
				req.raddr_b = i_q;
			end
			nep_pkg::ST_SUC_RD: begin
				req.raddr_a = p_q;
				req.raddr_b = s_q;
			end
			nep_pkg::ST_SUC_EV: begin
				req.we    = suc_found;
				req.waddr = p_q;
				req.wdata = rsp.rd_b;
			end
			nep_pkg::ST_SWP_WR: begin
				req.we    = 1'b1;
				req.waddr = s_q;
				req.wdata = hold_q;
			end
			nep_pkg::ST_REV_RD: begin
				req.raddr_a = lo_q;
				req.raddr_b = hi_q;
			end
			nep_pkg::ST_REV_EV: begin
				req.we    = 1'b1;
				req.waddr = lo_q;
				req.wdata = rsp.rd_b;
			end
			nep_pkg::ST_REV_WR: begin
				req.we    = 1'b1;
				req.waddr = hi_q;
				req.wdata = hold_q;
			end
			nep_pkg::ST_EMIT_WT: out_ch.valid = 1'b1;
			default: begin
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			nep_pkg::ST_IDLE: begin
				n_q     <= n_eff;
				i_q     <= nep_pkg::POS_W'(n_eff - nep_pkg::CNT_W'(1));
				k_q     <= '0;
				moved_q <= 1'b0;
			end
			nep_pkg::ST_PIV_EV: begin
				if (lt) begin
					p_q <= i_q - nep_pkg::POS_W'(1);
					s_q <= n_last;
				end else begin
					i_q <= i_q - nep_pkg::POS_W'(1);
				end
			end
			nep_pkg::ST_SUC_EV: begin
				hold_q <= rsp.rd_a;
				if (!suc_found) begin
					s_q <= s_q - nep_pkg::POS_W'(1);
				end
			end
			nep_pkg::ST_SWP_WR: begin
				moved_q <= 1'b1;
				lo_q    <= p_next;
				hi_q    <= n_last;
			end
			nep_pkg::ST_REV_EV: hold_q <= rsp.rd_a;
			nep_pkg::ST_REV_WR: begin
				lo_q <= lo_q + nep_pkg::POS_W'(1);
				hi_q <= hi_q - nep_pkg::POS_W'(1);
			end
			nep_pkg::ST_EMIT_LD: begin
				out_pos_q  <= k_q;
				out_val_q  <= rsp.rd_a;
				out_adv_q  <= moved_q;
				out_last_q <= k_last;
			end
			nep_pkg::ST_EMIT_WT: begin
				if (out_ch.ready) begin
					k_q <= k_q + nep_pkg::POS_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_ch.out_position = out_pos_q;
	assign out_ch.out_value    = out_val_q;
	assign out_ch.advanced     = out_adv_q;
	assign out_ch.last_of_run  = out_last_q;

endmodule

`default_nettype wire
